FILE: design/slrg_pkg.sv
// Shared types and constants for the shuffled Lehmer random generator.
// Used by the front end, the item queue and the back-end sequencer.
package slrg_pkg;

   localparam int          DATA_W    = 32;
   localparam int          SPAN_W    = 33;
   localparam int          RAW_W     = 31;
   localparam int          PP_W      = 50;
   localparam int          PROD_W    = 64;
   localparam logic [30:0] LCG_MOD   = 31'h7FFF_FFFF;
   localparam logic [14:0] LCG_MULT  = 15'd16807;
   localparam int          QUEUE_DEPTH = 2;

   typedef enum logic [0:0] {
      KIND_START,
      KIND_NORMAL
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic signed [DATA_W-1:0]  lo;
      logic signed [SPAN_W-1:0]  span;
   } entry_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_INIT_LOAD,
      BK_INIT_MUL,
      BK_INIT_RED,
      BK_SEL_MUL,
      BK_SEL_FIX,
      BK_READ,
      BK_WRITE,
      BK_SUM,
      BK_OUT
   } back_state_type;

endpackage

FILE: design/shuffled_lehmer_random_generator.sv
// Items are handled one at a time; the first item after reset first warms up the
// core and fills the table. The back end takes no new item until it has returned
// to idle, after core step, entry select, table read, table write with split scaling
// multiply, product sum and output, which waits while the response is not taken.
// Reset: synchronous, active high; seed returns to 1, the table is not cleared
// and is filled at start-up before any read.
module shuffled_lehmer_random_generator
   import slrg_pkg::*;
#(
   parameter int TABLE_ENTRIES = 32,
   parameter int EXTRA_WARMUP  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,     // [31:0] low_bound, [63:32] high_bound
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,     // [30:0] raw_value, [62:31] scaled_value
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [0:0] SEED_INDEX = 1'b0;

   logic [RAW_W-1:0] seed_ff, seed_in;
   logic             seed_wr;
   logic             push_valid;
   logic             push_ready;
   entry_type        push_entry;
   logic             pop_valid;
   logic             pop_ready;
   entry_type        pop_entry;

   assign csr_pready = 1'b1;
   assign seed_wr    = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_paddr[2] == SEED_INDEX);
   assign seed_in    = seed_wr ? csr_pwdata[RAW_W-1:0] : seed_ff;
   assign csr_prdata = (csr_paddr[2] == SEED_INDEX) ? {1'b0, seed_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 31'd1;
      end else begin
         seed_ff <= seed_in;
      end
   end

   slrg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   slrg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   slrg_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .EXTRA_WARMUP  (EXTRA_WARMUP)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .seed       (seed_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: design/slrg_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module slrg_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/slrg_front.sv
// Front end: accepts request items, tags the first one after reset as start-up,
// and forms the interval span. Depends on slrg_pkg.
module slrg_front
   import slrg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] low_bound, [63:32] high_bound
   output logic        push_valid,
   input  logic        push_ready,
   output entry_type   push_entry
);

   logic                      started_ff;
   logic                      started_in;
   logic signed [DATA_W-1:0]  lo;
   logic signed [DATA_W-1:0]  hi;

   assign lo = req_tdata[31:0];
   assign hi = req_tdata[63:32];

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;

   always_comb begin
      push_entry.kind = started_ff ? KIND_NORMAL : KIND_START;
      push_entry.lo   = lo;
      push_entry.span = {hi[DATA_W-1], hi} - {lo[DATA_W-1], lo};
   end

   assign started_in = started_ff | (req_tvalid & push_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
      end else begin
         started_ff <= started_in;
      end
   end

endmodule

FILE: design/slrg_queue.sv
// Short item queue between the front end and the back-end sequencer.
// Depends on slrg_pkg.
module slrg_queue
   import slrg_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_entry
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: design/slrg_back.sv
// Back-end sequencer: Lehmer core, shuffle table, entry select and scaling.
// Depends on slrg_pkg and slrg_ram.
module slrg_back
   import slrg_pkg::*;
#(
   parameter int TABLE_ENTRIES = 32,
   parameter int EXTRA_WARMUP  = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [RAW_W-1:0] seed,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  entry_type        pop_entry,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [63:0]      rsp_tdata   // [30:0] raw_value, [62:31] scaled_value
);

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int RECIP_W = IDX_W + 2;
   localparam int CNT_W   = $clog2(TABLE_ENTRIES + EXTRA_WARMUP + 1);
   localparam logic [31:0] SEL_DIV =
      32'(32'd1 + (32'(LCG_MOD) - 32'd1) / 32'(TABLE_ENTRIES));
   localparam logic [32:0] TWO_POW_32 = 33'h1_0000_0000;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(TWO_POW_32 / 33'(SEL_DIV));

   back_state_type             state_ff, state_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [RAW_W-1:0]           gen_ff, gen_in;
   logic [RAW_W-1:0]           last_ff, last_in;
   logic [45:0]                mul_ff, mul_in;
   logic [IDX_W-1:0]           qest_ff, qest_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic signed [DATA_W-1:0]   lo_ff, lo_in;
   logic signed [SPAN_W-1:0]   span_ff, span_in;
   logic [RAW_W-1:0]           raw_ff, raw_in;
   logic signed [PP_W-1:0]     pp_lo_ff, pp_lo_in;
   logic signed [PP_W-1:0]     pp_hi_ff, pp_hi_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RAW_W-1:0]           rsp_raw_ff, rsp_raw_in;
   logic [DATA_W-1:0]          rsp_scaled_ff, rsp_scaled_in;

   logic [31:0]                red_sum;
   logic [RAW_W-1:0]           red;
   logic [30+RECIP_W:0]        qprod;
   logic [IDX_W:0]             q_next;
   logic [IDX_W+32:0]          thr;
   logic                       hit;
   logic [IDX_W:0]             idx_sum;
   logic                       out_fire;

   logic                       ram_wr_en;
   logic [IDX_W-1:0]           ram_wr_addr;
   logic [RAW_W-1:0]           ram_wr_data;
   logic                       ram_rd_en;
   logic [RAW_W-1:0]           ram_rd_data;

   slrg_ram #(
      .WIDTH (RAW_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   // Mersenne reduction of the registered core product
   always_comb begin
      red_sum = {1'b0, mul_ff[30:0]} + 32'(mul_ff[45:31]);
      red     = (red_sum >= 32'(LCG_MOD)) ? 31'(red_sum - 32'(LCG_MOD)) : red_sum[30:0];
   end

   // Entry select: reciprocal estimate, then one-step correction
   always_comb begin
      qprod   = last_ff * RECIP;
      q_next  = {1'b0, qest_ff} + 1'b1;
      thr     = q_next * SEL_DIV;
      hit     = ((IDX_W + 33)'(last_ff) >= thr);
      idx_sum = {1'b0, qest_ff} + (IDX_W + 1)'(hit);
      if (idx_sum >= (IDX_W + 1)'(TABLE_ENTRIES)) begin
         idx_sum = idx_sum - (IDX_W + 1)'(TABLE_ENTRIES);
      end
   end

   assign out_fire = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               state_in = (pop_entry.kind == KIND_START) ? BK_INIT_LOAD : BK_SEL_MUL;
            end
         end
         BK_INIT_LOAD: state_in = BK_INIT_MUL;
         BK_INIT_MUL:  state_in = BK_INIT_RED;
         BK_INIT_RED:  state_in = (cnt_ff == '0) ? BK_SEL_MUL : BK_INIT_MUL;
         BK_SEL_MUL:   state_in = BK_SEL_FIX;
         BK_SEL_FIX:   state_in = BK_READ;
         BK_READ:      state_in = BK_WRITE;
         BK_WRITE:     state_in = BK_SUM;
         BK_SUM:       state_in = BK_OUT;
         BK_OUT: begin
            if (out_fire) begin
               state_in = BK_IDLE;
            end
         end
         default:      state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop_ready     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff;
      ram_wr_data   = gen_ff;
      ram_rd_en     = 1'b0;
      cnt_in        = cnt_ff;
      gen_in        = gen_ff;
      last_in       = last_ff;
      mul_in        = mul_ff;
      qest_in       = qest_ff;
      idx_in        = idx_ff;
      lo_in         = lo_ff;
      span_in       = span_ff;
      raw_in        = raw_ff;
      pp_lo_in      = pp_lo_ff;
      pp_hi_in      = pp_hi_ff;
      prod_in       = prod_ff;
      rsp_raw_in    = rsp_raw_ff;
      rsp_scaled_in = rsp_scaled_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            lo_in     = pop_entry.lo;
            span_in   = pop_entry.span;
         end
         BK_INIT_LOAD: begin
            gen_in = (seed == '0 || seed == LCG_MOD) ? 31'd1 : seed;
            cnt_in = CNT_W'(TABLE_ENTRIES + EXTRA_WARMUP - 1);
         end
         BK_INIT_MUL: begin
            mul_in = gen_ff * LCG_MULT;
         end
         BK_INIT_RED: begin
            gen_in      = red;
            ram_wr_en   = (cnt_ff < CNT_W'(TABLE_ENTRIES));
            ram_wr_addr = cnt_ff[IDX_W-1:0];
            ram_wr_data = red;
            if (cnt_ff == '0) begin
               last_in = red;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         BK_SEL_MUL: begin
            mul_in  = gen_ff * LCG_MULT;
            qest_in = qprod[32 +: IDX_W];
         end
         BK_SEL_FIX: begin
            gen_in = red;
            idx_in = idx_sum[IDX_W-1:0];
         end
         BK_READ: begin
            ram_rd_en = 1'b1;
         end
         BK_WRITE: begin
            ram_wr_en = 1'b1;
            raw_in    = ram_rd_data;
            last_in   = ram_rd_data;
            pp_lo_in  = span_ff * $signed({1'b0, ram_rd_data[15:0]});
            pp_hi_in  = span_ff * $signed({1'b0, ram_rd_data[30:16]});
         end
         BK_SUM: begin
            prod_in = (PROD_W'(pp_hi_ff) <<< 16) + PROD_W'(pp_lo_ff);
         end
         BK_OUT: begin
            if (out_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_raw_in    = raw_ff;
               rsp_scaled_in = lo_ff + prod_ff[62:31];
            end
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      gen_ff        <= gen_in;
      last_ff       <= last_in;
      mul_ff        <= mul_in;
      qest_ff       <= qest_in;
      idx_ff        <= idx_in;
      lo_ff         <= lo_in;
      span_ff       <= span_in;
      raw_ff        <= raw_in;
      pp_lo_ff      <= pp_lo_in;
      pp_hi_ff      <= pp_hi_in;
      prod_ff       <= prod_in;
      rsp_raw_ff    <= rsp_raw_in;
      rsp_scaled_ff <= rsp_scaled_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_scaled_ff, rsp_raw_ff};

endmodule
